### rtl/bips_pkg.sv
// Package for the battery and idle power supervisor.
// Beat types, event and power-mode codes, register indexes and fixed constants.
// No dependencies.
package bips_pkg;

    localparam int ADC_BITS   = 12;
    localparam int MV_W       = 13;
    localparam int TIMEOUT_W  = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int PROD_W     = 25;

    localparam logic [1:0] EV_TICK     = 2'd0;
    localparam logic [1:0] EV_SAMPLE   = 2'd1;
    localparam logic [1:0] EV_IDLE_RST = 2'd2;
    localparam logic [1:0] EV_SET_MODE = 2'd3;

    localparam logic [1:0] PM_SNOOZE = 2'd1;
    localparam logic [1:0] PM_SLEEP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_VOLTAGE = 1'b1;

    localparam logic [MV_W-1:0]      MV_OFFSET        = 13'd200;
    localparam logic [12:0]          MV_SLOPE         = 13'd6200;
    localparam logic [TIMEOUT_W-1:0] IDLE_SLEEP_FLOOR = 32'd60;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET    = 32'd120000;
    localparam logic [MV_W-1:0]      ALARM_RESET      = 13'd3000;

    typedef struct packed {
        logic [1:0]          mode;
        logic [ADC_BITS-1:0] adc_code;
        logic [1:0]          requested_power_mode;
    } in_item_t;

    typedef struct packed {
        logic [1:0]      power_state;
        logic            sense_enable;
        logic            adc_start;
        logic [MV_W-1:0] battery_millivolts;
    } out_item_t;

    typedef struct packed {
        logic     fire;
        in_item_t item;
    } step_t;

endpackage

### rtl/bips_mv_conv.sv
// ADC code to battery millivolts: ((code * 6200) >> 12) + 200.
// Depends on bips_pkg.
module bips_mv_conv (
    input  logic [bips_pkg::ADC_BITS-1:0] code,
    output logic [bips_pkg::MV_W-1:0]     millivolts
);
    import bips_pkg::*;

    logic [PROD_W-1:0] prod;

    assign prod       = PROD_W'(code) * PROD_W'(MV_SLOPE);
    assign millivolts = MV_W'(prod >> ADC_BITS) + MV_OFFSET;

endmodule

### rtl/bips_core.sv
// Supervisor state: phase counter, idle countdown, voltage, mode, sense, registers.
// Depends on bips_pkg and bips_mv_conv.
module bips_core #(
    parameter int TICKS_PER_PERIOD = 100
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bips_pkg::step_t                step,
    input  logic                           cfg_we,
    input  logic [bips_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bips_pkg::CFG_DATA_W-1:0] cfg_data,
    output bips_pkg::out_item_t            result
);
    import bips_pkg::*;

    localparam int PW = $clog2(TICKS_PER_PERIOD);
    localparam logic [PW-1:0] PH_SENSE_ON = PW'(0);
    localparam logic [PW-1:0] PH_START    = PW'(1);
    localparam logic [PW-1:0] PH_CHECK    = PW'(3);
    localparam logic [PW-1:0] PH_LAST     = PW'(TICKS_PER_PERIOD - 1);

    logic [PW-1:0]        phase_reg, phase_next;
    logic [TIMEOUT_W-1:0] countdown_reg, countdown_next;
    logic [MV_W-1:0]      volt_reg, volt_next;
    logic [1:0]           mode_reg, mode_next;
    logic                 sense_reg, sense_next;
    logic [TIMEOUT_W-1:0] timeout_reg, timeout_next;
    logic [MV_W-1:0]      alarm_reg, alarm_next;
    logic                 start;
    logic [MV_W-1:0]      sample_mv;

    bips_mv_conv u_mv_conv (
        .code       (step.item.adc_code),
        .millivolts (sample_mv)
    );

    always_comb
    begin
        phase_next     = phase_reg;
        countdown_next = countdown_reg;
        volt_next      = volt_reg;
        mode_next      = mode_reg;
        sense_next     = sense_reg;
        timeout_next   = timeout_reg;
        alarm_next     = alarm_reg;
        start          = 1'b0;
        if (step.fire)
        begin
            case (step.item.mode)
                EV_TICK:
                begin
                    phase_next = (phase_reg >= PH_LAST) ? '0 : phase_reg + PW'(1);
                    if (phase_reg == PH_SENSE_ON)
                    begin
                        sense_next = 1'b1;
                    end
                    else if (phase_reg == PH_START)
                    begin
                        start = 1'b1;
                    end
                    else if (phase_reg == PH_CHECK)
                    begin
                        sense_next = 1'b0;
                        if (volt_reg < alarm_reg)
                        begin
                            mode_next = PM_SLEEP;
                        end
                    end
                    if (countdown_reg == '0 && timeout_reg > IDLE_SLEEP_FLOOR)
                    begin
                        mode_next = PM_SLEEP;
                    end
                    countdown_next = countdown_reg - TIMEOUT_W'(1);
                end
                EV_SAMPLE:   volt_next = sample_mv;
                EV_IDLE_RST: countdown_next = timeout_reg;
                EV_SET_MODE: mode_next = step.item.requested_power_mode;
                default:     mode_next = step.item.requested_power_mode;
            endcase
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDLE_LIMIT:
                begin
                    timeout_next   = cfg_data;
                    countdown_next = cfg_data;
                end
                CFG_LOW_VOLTAGE: alarm_next = MV_W'(cfg_data);
                default:         alarm_next = alarm_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            countdown_reg <= TIMEOUT_RESET;
            volt_reg      <= '0;
            mode_reg      <= PM_SNOOZE;
            sense_reg     <= 1'b0;
            timeout_reg   <= TIMEOUT_RESET;
            alarm_reg     <= ALARM_RESET;
        end
        else
        begin
            phase_reg     <= phase_next;
            countdown_reg <= countdown_next;
            volt_reg      <= volt_next;
            mode_reg      <= mode_next;
            sense_reg     <= sense_next;
            timeout_reg   <= timeout_next;
            alarm_reg     <= alarm_next;
        end
    end

    assign result.power_state        = mode_next;
    assign result.sense_enable       = sense_next;
    assign result.adc_start          = start;
    assign result.battery_millivolts = volt_next;

endmodule

### rtl/battery_and_idle_power_supervisor.sv
// Top level of the battery and idle power supervisor: input register, core, result register.
// Depends on bips_pkg, bips_core.
//
//   channel  | handshake                  | beat
//   ---------+----------------------------+---------------------------------
//   item     | item_valid / item_ready    | in_item_t: event, ADC code, mode
//   result   | result_valid / result_ready| out_item_t: one per item
//   cfg      | cfg_valid / cfg_ready      | register index + write data
//
// One item per cycle while results are taken; each item passes both registers in turn.
// The throughput is set by the single state update stage behind the input register.
// A stalled result holds the stage; the input register still takes one item meanwhile.
// cfg_ready is low while an item waits in the input register.
// Reset is asynchronous, active low; no clearing pass, items accepted right after reset.
module battery_and_idle_power_supervisor #(
    parameter int TICKS_PER_PERIOD = 100
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  bips_pkg::in_item_t              item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output bips_pkg::out_item_t             result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bips_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bips_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bips_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      res_valid_reg;
    out_item_t res_reg;
    out_item_t core_result;
    step_t     step;
    logic      advance;
    logic      cfg_we;

    assign advance    = !res_valid_reg || result_ready;
    assign item_ready = !in_valid_reg || advance;
    assign cfg_ready  = !in_valid_reg;
    assign cfg_we     = cfg_valid && cfg_ready;
    assign step.fire  = in_valid_reg && advance;
    assign step.item  = in_item_reg;

    bips_core #(
        .TICKS_PER_PERIOD (TICKS_PER_PERIOD)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                in_valid_reg <= item_valid;
            end
            if (advance)
            begin
                res_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_item_reg <= item;
        end
        if (step.fire)
        begin
            res_reg <= core_result;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

### rtl/bips_checker.sv
// Port-level checks for the battery and idle power supervisor, bound to the top level.
// Depends on bips_pkg.
module bips_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                result_valid,
    input logic                result_ready,
    input bips_pkg::out_item_t result
);
    import bips_pkg::*;

    // ADC start comes one tick after the divider is switched on
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.adc_start |-> result.sense_enable)
        else $error("adc_start without sense_enable");

    // voltage is zero before any sample, otherwise within the conversion range
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.battery_millivolts == '0) ||
        ((result.battery_millivolts >= MV_OFFSET) && (result.battery_millivolts <= 13'd6398)))
        else $error("battery_millivolts out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result beat changed");

    // a nonzero voltage never returns to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready ##1 result_valid &&
        $past(result.battery_millivolts) != '0 |-> result.battery_millivolts != '0)
        else $error("battery_millivolts returned to zero");

endmodule

bind battery_and_idle_power_supervisor bips_checker u_bips_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
